[src/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// Transfer slot allocator package
// Request modes, response status codes and register indexes for the
// allocator; its checker shares the widths and status codes.
// ----------------------------------------------------------------------------
package tsa_pkg;

   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 5;
   localparam int ELEM_W   = 32;
   localparam int COVER_W  = 16;
   localparam int SLOTIX_W = 4;
   localparam int REGIX_W  = 2;
   localparam int PADDR_W  = 4;

   localparam logic [MODE_W-1:0] MODE_ASSIGN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PLACE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RETRY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DYNAMIC = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd3;

   localparam logic [REGIX_W-1:0] REG_SEND_SLOTS   = 2'd0;
   localparam logic [REGIX_W-1:0] REG_RECV_SLOTS   = 2'd1;
   localparam logic [REGIX_W-1:0] REG_DYNAMIC_ONLY = 2'd2;
   localparam logic [REGIX_W-1:0] REG_BUFFER_ELEMS = 2'd3;

   localparam logic [COVER_W-1:0] COVER_MAX = 16'hFFFF;

endpackage

[src/transfer_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// Transfer slot allocator
// Two pools of fixed transfer buffer slots (send and receive), each with a
// held bitmap and an in-use count; assigns the lowest free slot, frees slots
// and packs slices of a run into a held slot.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high and busy is low; busy is high only
// during reset and in the cycle after it. Each request gives exactly one
// response beat, marked by rsp_valid for one cycle; requests may be issued
// every cycle and responses come back in order at the same rate. The receiver
// cannot stall: each response beat must be taken in the one cycle in which it
// is shown. Each response passes through the request register followed by the
// response register, with the slot priority encoder and the offset add and
// capacity compare between them. The user must write registers over the APB
// port only while no request is in flight; the block does not enforce this.
module transfer_slot_allocator_top #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [tsa_pkg::MODE_W-1:0]      req_mode,
   input  logic                            req_pool,
   input  logic [tsa_pkg::SLOTIX_W-1:0]    req_slot_index,
   input  logic [tsa_pkg::ELEM_W-1:0]      req_element_count,
   input  logic                            req_first_slice,
   output logic                            rsp_valid,
   output logic [tsa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [tsa_pkg::SLOTIX_W-1:0]    rsp_granted_slot,
   output logic [tsa_pkg::ELEM_W-1:0]      rsp_slice_offset,
   output logic                            rsp_slice_in_slot,
   output logic [tsa_pkg::COVER_W-1:0]     rsp_covered_count,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tsa_pkg::PADDR_W-1:0]     paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > tsa_pkg::CFG_W) ? CNT_W : tsa_pkg::CFG_W;
   localparam int HELD_W = (MAX_SLOTS > 16) ? MAX_SLOTS : 16;
   localparam int HIDX_W = $clog2(HELD_W);
   localparam int GNT_W  = (SLOT_W > tsa_pkg::SLOTIX_W) ? SLOT_W : tsa_pkg::SLOTIX_W;

   // Configuration registers.
   logic [tsa_pkg::CFG_W-1:0]  send_slots_ff, recv_slots_ff;
   logic                       dyn_only_ff;
   logic [tsa_pkg::ELEM_W-1:0] buf_elems_ff;
   logic                       cfg_write;
   logic [tsa_pkg::REGIX_W-1:0] cfg_index;

   // Request register.
   logic                         busy_ff;
   logic                         req_valid_ff;
   logic [tsa_pkg::MODE_W-1:0]   mode_ff;
   logic                         pool_ff;
   logic [tsa_pkg::SLOTIX_W-1:0] slot_ff;
   logic [tsa_pkg::ELEM_W-1:0]   count_ff;
   logic                         first_ff;

   // Allocator state.
   logic [MAX_SLOTS-1:0]        send_held_ff, send_held_in;
   logic [MAX_SLOTS-1:0]        recv_held_ff, recv_held_in;
   logic [CNT_W-1:0]            send_use_ff, send_use_in;
   logic [CNT_W-1:0]            recv_use_ff, recv_use_in;
   logic [tsa_pkg::ELEM_W-1:0]  run_offset_ff, run_offset_in;
   logic [tsa_pkg::COVER_W-1:0] run_covered_ff, run_covered_in;

   // Response register.
   logic                         rsp_valid_ff;
   logic [tsa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [tsa_pkg::SLOTIX_W-1:0] granted_ff, granted_in;
   logic [tsa_pkg::ELEM_W-1:0]   offset_ff, offset_in;
   logic                         in_slot_ff, in_slot_in;
   logic [tsa_pkg::COVER_W-1:0]  covered_ff, covered_in;

   // Datapath intermediates.
   logic [CMP_W-1:0]            slots_cfg, slots_lim;
   logic [MAX_SLOTS-1:0]        cur_held, new_held, free_mask;
   logic [HELD_W-1:0]           held_wide, held_wide_clr;
   logic [HIDX_W-1:0]           slot_idx;
   logic [CNT_W-1:0]            cur_use, new_use;
   logic                        slot_ok, found;
   logic [SLOT_W-1:0]           grant_idx;
   logic [GNT_W-1:0]            grant_wide;
   logic [tsa_pkg::ELEM_W-1:0]  base_offset;
   logic [tsa_pkg::COVER_W-1:0] base_covered, bumped_covered;
   logic [tsa_pkg::ELEM_W:0]    slice_end;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[tsa_pkg::PADDR_W-1:2];

   always_comb begin
      unique case (cfg_index)
         tsa_pkg::REG_SEND_SLOTS:   prdata = 32'(send_slots_ff);
         tsa_pkg::REG_RECV_SLOTS:   prdata = 32'(recv_slots_ff);
         tsa_pkg::REG_DYNAMIC_ONLY: prdata = 32'(dyn_only_ff);
         tsa_pkg::REG_BUFFER_ELEMS: prdata = buf_elems_ff;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_slots_ff <= tsa_pkg::CFG_W'(1);
         recv_slots_ff <= tsa_pkg::CFG_W'(1);
         dyn_only_ff   <= 1'b0;
         buf_elems_ff  <= '0;
      end else if (cfg_write) begin
         unique case (cfg_index)
            tsa_pkg::REG_SEND_SLOTS:   send_slots_ff <= pwdata[tsa_pkg::CFG_W-1:0];
            tsa_pkg::REG_RECV_SLOTS:   recv_slots_ff <= pwdata[tsa_pkg::CFG_W-1:0];
            tsa_pkg::REG_DYNAMIC_ONLY: dyn_only_ff   <= pwdata[0];
            tsa_pkg::REG_BUFFER_ELEMS: buf_elems_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   // Request register: a new beat may enter every cycle while busy is low.
   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         mode_ff  <= req_mode;
         pool_ff  <= req_pool;
         slot_ff  <= req_slot_index;
         count_ff <= req_element_count;
         first_ff <= req_first_slice;
      end
   end

   // Single-pass evaluation of the registered request against the pool state.
   always_comb begin
      slots_cfg = CMP_W'(pool_ff ? recv_slots_ff : send_slots_ff);
      slots_lim = (slots_cfg > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : slots_cfg;
      cur_held  = pool_ff ? recv_held_ff : send_held_ff;
      cur_use   = pool_ff ? recv_use_ff : send_use_ff;

      held_wide = HELD_W'(cur_held);
      slot_idx  = HIDX_W'(slot_ff);
      slot_ok   = (CMP_W'(slot_ff) < slots_lim) && held_wide[slot_idx];

      // Lowest free slot below the usable count; scanning downward lets the
      // lowest index win.
      for (int i = 0; i < MAX_SLOTS; i++) begin
         free_mask[i] = !cur_held[i] && (CMP_W'(i) < slots_lim);
      end
      found     = 1'b0;
      grant_idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (free_mask[i]) begin
            found     = 1'b1;
            grant_idx = SLOT_W'(i);
         end
      end
      grant_wide = GNT_W'(grant_idx);

      held_wide_clr           = held_wide;
      held_wide_clr[slot_idx] = 1'b0;

      base_offset    = first_ff ? '0 : run_offset_ff;
      base_covered   = first_ff ? '0 : run_covered_ff;
      bumped_covered = (base_covered == tsa_pkg::COVER_MAX) ? base_covered
                                                             : base_covered + 1'b1;
      slice_end      = {1'b0, base_offset} + {1'b0, count_ff};

      new_held       = cur_held;
      new_use        = cur_use;
      run_offset_in  = run_offset_ff;
      run_covered_in = run_covered_ff;
      status_in      = tsa_pkg::STATUS_OK;
      granted_in     = '0;
      offset_in      = '0;
      in_slot_in     = 1'b0;
      covered_in     = '0;

      case (mode_ff)
         tsa_pkg::MODE_ASSIGN: begin
            if (dyn_only_ff) begin
               status_in = tsa_pkg::STATUS_DYNAMIC;
            end else if (CMP_W'(cur_use) >= slots_lim || !found) begin
               status_in = tsa_pkg::STATUS_RETRY;
            end else begin
               new_held[grant_idx] = 1'b1;
               new_use             = cur_use + 1'b1;
               granted_in          = grant_wide[tsa_pkg::SLOTIX_W-1:0];
            end
         end
         tsa_pkg::MODE_FREE: begin
            if (dyn_only_ff) begin
               status_in = tsa_pkg::STATUS_DYNAMIC;
            end else if (!slot_ok) begin
               status_in = tsa_pkg::STATUS_BAD;
            end else begin
               new_held = held_wide_clr[MAX_SLOTS-1:0];
               if (cur_use != '0) begin
                  new_use = cur_use - 1'b1;
               end
            end
         end
         tsa_pkg::MODE_PLACE: begin
            if (dyn_only_ff) begin
               // Every slice goes dynamic but still counts as covered.
               status_in      = tsa_pkg::STATUS_DYNAMIC;
               run_offset_in  = base_offset;
               run_covered_in = bumped_covered;
               covered_in     = bumped_covered;
            end else if (!slot_ok) begin
               status_in  = tsa_pkg::STATUS_BAD;
               covered_in = run_covered_ff;
            end else if (slice_end <= {1'b0, buf_elems_ff}) begin
               offset_in      = base_offset;
               in_slot_in     = 1'b1;
               run_offset_in  = slice_end[tsa_pkg::ELEM_W-1:0];
               run_covered_in = bumped_covered;
               covered_in     = bumped_covered;
            end else begin
               run_offset_in  = base_offset;
               run_covered_in = base_covered;
               covered_in     = base_covered;
            end
         end
         default: begin
            status_in = tsa_pkg::STATUS_BAD;
         end
      endcase

      send_held_in = send_held_ff;
      recv_held_in = recv_held_ff;
      send_use_in  = send_use_ff;
      recv_use_in  = recv_use_ff;
      if (pool_ff) begin
         recv_held_in = new_held;
         recv_use_in  = new_use;
      end else begin
         send_held_in = new_held;
         send_use_in  = new_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_held_ff   <= '0;
         recv_held_ff   <= '0;
         send_use_ff    <= '0;
         recv_use_ff    <= '0;
         run_offset_ff  <= '0;
         run_covered_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            send_held_ff   <= send_held_in;
            recv_held_ff   <= recv_held_in;
            send_use_ff    <= send_use_in;
            recv_use_ff    <= recv_use_in;
            run_offset_ff  <= run_offset_in;
            run_covered_ff <= run_covered_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         offset_ff  <= offset_in;
         in_slot_ff <= in_slot_in;
         covered_ff <= covered_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_slot  = granted_ff;
   assign rsp_slice_offset  = offset_ff;
   assign rsp_slice_in_slot = in_slot_ff;
   assign rsp_covered_count = covered_ff;

endmodule

[src/tsa_checker.sv]
// ----------------------------------------------------------------------------
// Transfer slot allocator checker
// Port-level checks on response timing and field consistency, bound to the
// allocator top level.
// ----------------------------------------------------------------------------
module tsa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [tsa_pkg::STATUS_W-1:0] rsp_status,
   input logic [tsa_pkg::SLOTIX_W-1:0] rsp_granted_slot,
   input logic [tsa_pkg::ELEM_W-1:0]   rsp_slice_offset,
   input logic                         rsp_slice_in_slot,
   input logic [tsa_pkg::COVER_W-1:0]  rsp_covered_count
);

   // Every accepted request produces its response beat.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("response beat missing after accepted request");

   // No response beat without an earlier accepted request.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response beat without a request");

   // A slice placed in a slot always comes with an ok status.
   a_placed_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_slice_in_slot) |-> (rsp_status == tsa_pkg::STATUS_OK))
      else $error("slice placed with non-ok status");

   // A failed request never reports a placement offset or a granted slot.
   a_fail_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != tsa_pkg::STATUS_OK)) |->
         (rsp_slice_offset == '0 && !rsp_slice_in_slot && rsp_granted_slot == '0))
      else $error("failed request reports slot or offset");

   // A nonzero granted slot comes only from an assign, which reports no coverage.
   a_grant_no_cover: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_granted_slot != '0)) |-> (rsp_covered_count == '0))
      else $error("granted slot with covered count");

endmodule

bind transfer_slot_allocator_top tsa_checker u_tsa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_granted_slot  (rsp_granted_slot),
   .rsp_slice_offset  (rsp_slice_offset),
   .rsp_slice_in_slot (rsp_slice_in_slot),
   .rsp_covered_count (rsp_covered_count)
);
